>>> rtl/mrs_pkg.sv
// Shared types, constants and the CRC step of the Modbus RTU register server.
// No dependencies; imported by mrs_front, mrs_back, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package mrs_pkg;

    localparam int RX_BUF_BYTES_DEF  = 64;
    localparam int HOLDING_COUNT_DEF = 16;
    localparam int INPUT_COUNT_DEF   = 16;
    localparam int DIAG_COUNT_DEF    = 8;

    localparam int CMD_FIFO_DEPTH = 2;
    localparam int RES_FIFO_DEPTH = 4;

    localparam int LEN_W   = 9;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_SEED = 16'hFFFF;
    localparam logic [7:0]  EXC_FLAG = 8'h80;

    localparam logic [7:0] SA_RESET  = 8'd255;
    localparam logic [15:0] GTO_RESET = 16'd4;

    localparam logic REG_SLAVE_ADDR = 1'b0;
    localparam logic REG_GAP_TICKS  = 1'b1;

    localparam logic [1:0] FUNC_BYTE  = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_INREG = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    localparam logic [7:0] FN_READ_COILS    = 8'h01;
    localparam logic [7:0] FN_READ_DISCRETE = 8'h02;
    localparam logic [7:0] FN_READ_HOLDING  = 8'h03;
    localparam logic [7:0] FN_READ_INPUT    = 8'h04;
    localparam logic [7:0] FN_WRITE_COIL    = 8'h05;
    localparam logic [7:0] FN_WRITE_SINGLE  = 8'h06;
    localparam logic [7:0] FN_DIAG          = 8'h08;
    localparam logic [7:0] FN_WRITE_COILS   = 8'h0F;
    localparam logic [7:0] FN_WRITE_MULTI   = 8'h10;

    localparam logic [7:0] EXC_ILLEGAL_FUNC  = 8'h01;
    localparam logic [7:0] EXC_ILLEGAL_ADDR  = 8'h02;
    localparam logic [7:0] EXC_ILLEGAL_VALUE = 8'h03;

    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_NOTICE = 1'b1;

    typedef enum logic {
        CMD_FRAME,
        CMD_INREG
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [LEN_W-1:0] len;
        logic [3:0]       idx;
        logic [15:0]      value;
    } cmd_t;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [3:0]  written_index;
        logic [15:0] written_value;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CRC,
        S_CHECK,
        S_WR6,
        S_WRHI,
        S_WRLO,
        S_WREM,
        S_SEND,
        S_TXLO,
        S_TXHI,
        S_DONE
    } back_state_t;

    typedef enum logic [1:0] {
        MODE_EXC,
        MODE_READ,
        MODE_ECHO
    } resp_mode_t;

    typedef enum logic [1:0] {
        SRC_HOLD,
        SRC_INPUT,
        SRC_DIAG
    } reg_src_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/mrs_ram.sv
// Generic single write port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/mrs_fifo.sv
// Small flop-based FIFO used between front, back and result port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mrs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output      logic             full,
    input  wire logic             rd_en,
    output      logic [WIDTH-1:0] rd_data,
    output      logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wp_reg, wp_next, rp_reg, rp_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = slot_reg[rp_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_wr)
        begin
            wp_next = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (do_rd)
        begin
            rp_next = (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wp_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/mrs_front.sv
// Receive front: accepts transactions, frames requests into the receive RAM,
// runs the gap timer and queues frame and input register commands. Uses mrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrs_front
    import mrs_pkg::*;
#(
    parameter int RX_BUF_BYTES = RX_BUF_BYTES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output      logic                            full,
    input  wire logic [1:0]                      func,
    input  wire logic [7:0]                      data_byte,
    input  wire logic [3:0]                      reg_index,
    input  wire logic [15:0]                     reg_value,
    input  wire logic [7:0]                      slave_address,
    input  wire logic [15:0]                     gap_timeout_ticks,
    output      logic                            ram_we,
    output      logic [$clog2(RX_BUF_BYTES)-1:0] ram_waddr,
    output      logic                            cmd_push,
    output      cmd_t                            cmd_data,
    input  wire logic                            cmd_full,
    input  wire logic                            frame_done
);

    localparam int CNT_W = $clog2(RX_BUF_BYTES + 1);
    localparam int AW    = $clog2(RX_BUF_BYTES);

    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_inc;
    logic [15:0]      gap_reg, gap_next, gap_inc;
    logic [7:0]       b0_reg, b0_next, fn_reg, fn_next, b6_reg, b6_next, b6_eff;
    logic             pend_reg, pend_next;
    logic             accept, take_frame;
    logic [LEN_W:0]   expect_len;

    assign full      = pend_reg || cmd_full;
    assign accept    = push && !full;
    assign ram_waddr = cnt_reg[AW-1:0];
    assign cnt_inc   = cnt_reg + 1'b1;
    assign b6_eff    = (cnt_reg == CNT_W'(6)) ? data_byte : b6_reg;
    assign expect_len = (LEN_W + 1)'(b6_eff) + (LEN_W + 1)'(9);
    assign gap_inc   = (gap_reg == 16'hFFFF) ? gap_reg : gap_reg + 1'b1;

    always_comb
    begin
        cnt_next   = cnt_reg;
        gap_next   = gap_reg;
        b0_next    = b0_reg;
        fn_next    = fn_reg;
        b6_next    = b6_reg;
        pend_next  = pend_reg;
        ram_we     = 1'b0;
        take_frame = 1'b0;
        cmd_push   = 1'b0;
        cmd_data   = '0;
        if (frame_done)
        begin
            pend_next = 1'b0;
        end
        if (accept)
        begin
            unique case (func)
                FUNC_BYTE:
                begin
                    gap_next = '0;
                    if (cnt_reg != CNT_W'(RX_BUF_BYTES))
                    begin
                        ram_we   = 1'b1;
                        cnt_next = cnt_inc;
                        if (cnt_reg == CNT_W'(0)) b0_next = data_byte;
                        if (cnt_reg == CNT_W'(1)) fn_next = data_byte;
                        if (cnt_reg == CNT_W'(6)) b6_next = data_byte;
                        if (cnt_reg >= CNT_W'(4))
                        begin
                            if (b0_reg != slave_address && b0_reg != 8'h00)
                            begin
                                cnt_next = '0;
                            end
                            else
                            begin
                                case (fn_reg) inside
                                    FN_READ_COILS, FN_READ_DISCRETE, FN_READ_HOLDING,
                                    FN_READ_INPUT, FN_WRITE_COIL, FN_WRITE_SINGLE,
                                    FN_DIAG:
                                        take_frame = (cnt_inc == CNT_W'(8));
                                    FN_WRITE_COILS, FN_WRITE_MULTI:
                                        take_frame = (cnt_inc >= CNT_W'(7)) &&
                                                     ((LEN_W + 1)'(cnt_inc) == expect_len);
                                    default:
                                        cnt_next = '0;
                                endcase
                            end
                        end
                    end
                    if (take_frame)
                    begin
                        cnt_next       = '0;
                        pend_next      = 1'b1;
                        cmd_push       = 1'b1;
                        cmd_data.kind  = CMD_FRAME;
                        cmd_data.len   = LEN_W'(cnt_inc);
                    end
                end
                FUNC_TICK:
                begin
                    if (gap_inc >= gap_timeout_ticks)
                    begin
                        gap_next = '0;
                        cnt_next = '0;
                    end
                    else
                    begin
                        gap_next = gap_inc;
                    end
                end
                FUNC_INREG:
                begin
                    cmd_push       = 1'b1;
                    cmd_data.kind  = CMD_INREG;
                    cmd_data.idx   = reg_index;
                    cmd_data.value = reg_value;
                end
                FUNC_NONE:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            gap_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            gap_reg  <= gap_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b0_reg <= b0_next;
        fn_reg <= fn_next;
        b6_reg <= b6_next;
    end

endmodule

`default_nettype wire

>>> rtl/mrs_back.sv
// Request back end: checks the frame CRC from the receive RAM, serves the
// register functions and queues response bytes and write notices. Uses mrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrs_back
    import mrs_pkg::*;
#(
    parameter int RX_BUF_BYTES  = RX_BUF_BYTES_DEF,
    parameter int HOLDING_COUNT = HOLDING_COUNT_DEF,
    parameter int INPUT_COUNT   = INPUT_COUNT_DEF,
    parameter int DIAG_COUNT    = DIAG_COUNT_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [7:0]                      slave_address,
    output      logic                            cmd_pop,
    input  wire cmd_t                            cmd_data,
    input  wire logic                            cmd_empty,
    output      logic [$clog2(RX_BUF_BYTES)-1:0] ram_raddr,
    input  wire logic [7:0]                      ram_rdata,
    output      logic                            out_push,
    output      res_t                            out_data,
    input  wire logic                            out_full,
    output      logic                            frame_done
);

    localparam int AW  = $clog2(RX_BUF_BYTES);
    localparam int HAW = (HOLDING_COUNT > 1) ? $clog2(HOLDING_COUNT) : 1;
    localparam int IAW = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
    localparam int DAW = $clog2(DIAG_COUNT);

    back_state_t      state_reg, state_next;
    logic [LEN_W-1:0] len_reg, len_next, rd_reg, rd_next, pidx_reg, pidx_next;
    logic             vld_reg, vld_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       hdr_reg [7];
    logic [7:0]       hdr_next [7];
    logic [7:0]       clo_reg, clo_next, chi_reg, chi_next, code_reg, code_next;
    logic [7:0]       whi_reg, whi_next;
    resp_mode_t       mode_reg, mode_next;
    reg_src_t         src_reg, src_next;
    logic [6:0]       j_reg, j_next;
    logic [4:0]       wi_reg, wi_next;

    logic [15:0] hold_reg [HOLDING_COUNT];
    logic [15:0] inr_reg [INPUT_COUNT];
    logic [15:0] diag_reg [DIAG_COUNT];
    logic        hold_we, inr_we, diag_rx_inc, diag_tx_inc;
    logic [4:0]  hold_widx;
    logic [15:0] hold_wdata;

    logic        bcast, crc_ok, rd_fault, wr6_fault, wr16_fault, wr_last;
    logic [7:0]  fn;
    logic [15:0] start, qty;
    logic [16:0] span;
    logic [16:0] rd_count;
    logic [6:0]  resp_len, k;
    logic [5:0]  ridx;
    logic [15:0] rval;
    logic [7:0]  tx_b;

    assign fn        = hdr_reg[1];
    assign bcast     = (hdr_reg[0] == 8'h00);
    assign start     = {hdr_reg[2], hdr_reg[3]};
    assign qty       = {hdr_reg[4], hdr_reg[5]};
    assign span      = {1'b0, start} + {1'b0, qty};
    assign crc_ok    = ({chi_reg, clo_reg} == crc_reg);
    assign rd_count  = (fn == FN_READ_HOLDING) ? 17'(HOLDING_COUNT) :
                       (fn == FN_READ_INPUT)   ? 17'(INPUT_COUNT) : 17'(DIAG_COUNT);
    assign rd_fault  = (span > rd_count);
    assign wr6_fault = (start >= 16'(HOLDING_COUNT));
    assign wr16_fault = ({qty, 1'b0} != {9'b0, hdr_reg[6]}) ||
                        (span > 17'(HOLDING_COUNT));
    assign wr_last   = ({11'b0, wi_reg} + 16'd1 == qty);
    assign resp_len  = (mode_reg == MODE_EXC)  ? 7'd3 :
                       (mode_reg == MODE_ECHO) ? 7'd6 : 7'd3 + {qty[5:0], 1'b0};
    assign k         = j_reg - 7'd3;
    assign ridx      = 6'(start[4:0]) + 6'(k[6:1]);

    always_comb
    begin
        case (src_reg)
            SRC_HOLD:  rval = hold_reg[ridx[HAW-1:0]];
            SRC_INPUT: rval = inr_reg[ridx[IAW-1:0]];
            default:   rval = diag_reg[ridx[DAW-1:0]];
        endcase
        tx_b = slave_address;
        if (j_reg == 7'd1)
        begin
            tx_b = (mode_reg == MODE_EXC) ? (fn | EXC_FLAG) : fn;
        end
        else if (j_reg >= 7'd2)
        begin
            case (mode_reg)
                MODE_EXC:  tx_b = code_reg;
                MODE_ECHO: tx_b = hdr_reg[j_reg[2:0]];
                default:
                    if (j_reg == 7'd2)
                        tx_b = {qty[6:0], 1'b0};
                    else
                        tx_b = k[0] ? rval[7:0] : rval[15:8];
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (!cmd_empty && cmd_data.kind == CMD_FRAME) state_next = S_CRC;
            S_CRC:
                if (vld_reg && pidx_reg == len_reg - 1'b1) state_next = S_CHECK;
            S_CHECK:
            begin
                if (!crc_ok)
                    state_next = S_DONE;
                else
                begin
                    case (fn) inside
                        FN_READ_HOLDING, FN_READ_INPUT, FN_DIAG:
                            state_next = bcast ? S_DONE : S_SEND;
                        FN_WRITE_SINGLE:
                            state_next = wr6_fault ? (bcast ? S_DONE : S_SEND) : S_WR6;
                        FN_WRITE_MULTI:
                            if (wr16_fault || qty == 16'd0)
                                state_next = bcast ? S_DONE : S_SEND;
                            else
                                state_next = S_WRHI;
                        default:
                            state_next = bcast ? S_DONE : S_SEND;
                    endcase
                end
            end
            S_WR6:
                if (!out_full) state_next = bcast ? S_DONE : S_SEND;
            S_WRHI:
                state_next = S_WRLO;
            S_WRLO:
                state_next = S_WREM;
            S_WREM:
                if (!out_full) state_next = wr_last ? (bcast ? S_DONE : S_SEND) : S_WRHI;
            S_SEND:
                if (!out_full && j_reg + 7'd1 == resp_len) state_next = S_TXLO;
            S_TXLO:
                if (!out_full) state_next = S_TXHI;
            S_TXHI:
                if (!out_full) state_next = S_DONE;
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        len_next    = len_reg;
        rd_next     = rd_reg;
        pidx_next   = pidx_reg;
        vld_next    = 1'b0;
        crc_next    = crc_reg;
        hdr_next    = hdr_reg;
        clo_next    = clo_reg;
        chi_next    = chi_reg;
        code_next   = code_reg;
        whi_next    = whi_reg;
        mode_next   = mode_reg;
        src_next    = src_reg;
        j_next      = j_reg;
        wi_next     = wi_reg;
        cmd_pop     = 1'b0;
        ram_raddr   = '0;
        out_push    = 1'b0;
        out_data    = '0;
        hold_we     = 1'b0;
        hold_widx   = '0;
        hold_wdata  = '0;
        inr_we      = 1'b0;
        diag_rx_inc = 1'b0;
        diag_tx_inc = 1'b0;
        frame_done  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop  = 1'b1;
                    inr_we   = (cmd_data.kind == CMD_INREG) &&
                               ({1'b0, cmd_data.idx} < 5'(INPUT_COUNT));
                    len_next = cmd_data.len;
                    rd_next  = '0;
                    crc_next = CRC_SEED;
                end
            end
            S_CRC:
            begin
                if (rd_reg < len_reg)
                begin
                    ram_raddr = rd_reg[AW-1:0];
                    rd_next   = rd_reg + 1'b1;
                    vld_next  = 1'b1;
                    pidx_next = rd_reg;
                end
                if (vld_reg)
                begin
                    if (pidx_reg + LEN_W'(2) < len_reg)
                        crc_next = crc_byte(crc_reg, ram_rdata);
                    if (pidx_reg < LEN_W'(7))
                        hdr_next[pidx_reg[2:0]] = ram_rdata;
                    if (pidx_reg == len_reg - LEN_W'(2))
                        clo_next = ram_rdata;
                    if (pidx_reg == len_reg - LEN_W'(1))
                        chi_next = ram_rdata;
                end
            end
            S_CHECK:
            begin
                diag_rx_inc = crc_ok;
                crc_next    = CRC_SEED;
                j_next      = '0;
                wi_next     = '0;
                mode_next   = MODE_EXC;
                src_next    = SRC_DIAG;
                case (fn) inside
                    FN_READ_HOLDING, FN_READ_INPUT, FN_DIAG:
                    begin
                        mode_next = rd_fault ? MODE_EXC : MODE_READ;
                        code_next = EXC_ILLEGAL_ADDR;
                        src_next  = (fn == FN_READ_HOLDING) ? SRC_HOLD :
                                    (fn == FN_READ_INPUT) ? SRC_INPUT : SRC_DIAG;
                    end
                    FN_WRITE_SINGLE:
                    begin
                        mode_next = wr6_fault ? MODE_EXC : MODE_ECHO;
                        code_next = EXC_ILLEGAL_VALUE;
                    end
                    FN_WRITE_MULTI:
                    begin
                        mode_next = wr16_fault ? MODE_EXC : MODE_ECHO;
                        code_next = EXC_ILLEGAL_VALUE;
                    end
                    default:
                        code_next = EXC_ILLEGAL_FUNC;
                endcase
            end
            S_WR6:
            begin
                if (!out_full)
                begin
                    hold_we                = 1'b1;
                    hold_widx              = start[4:0];
                    hold_wdata             = qty;
                    out_push               = 1'b1;
                    out_data.out_kind      = KIND_NOTICE;
                    out_data.last          = bcast;
                    out_data.written_index = start[3:0];
                    out_data.written_value = qty;
                end
            end
            S_WRHI:
                ram_raddr = AW'(LEN_W'(7) + {3'b0, wi_reg, 1'b0});
            S_WRLO:
            begin
                ram_raddr = AW'(LEN_W'(8) + {3'b0, wi_reg, 1'b0});
                whi_next  = ram_rdata;
            end
            S_WREM:
            begin
                ram_raddr = AW'(LEN_W'(8) + {3'b0, wi_reg, 1'b0});
                if (!out_full)
                begin
                    hold_we                = 1'b1;
                    hold_widx              = start[4:0] + wi_reg;
                    hold_wdata             = {whi_reg, ram_rdata};
                    out_push               = 1'b1;
                    out_data.out_kind      = KIND_NOTICE;
                    out_data.last          = bcast && wr_last;
                    out_data.written_index = hold_widx[3:0];
                    out_data.written_value = hold_wdata;
                    wi_next                = wi_reg + 1'b1;
                end
            end
            S_SEND:
            begin
                if (!out_full)
                begin
                    out_push         = 1'b1;
                    out_data.out_kind = KIND_TX;
                    out_data.tx_byte = tx_b;
                    crc_next         = crc_byte(crc_reg, tx_b);
                    j_next           = j_reg + 1'b1;
                end
            end
            S_TXLO:
            begin
                out_push          = !out_full;
                out_data.out_kind = KIND_TX;
                out_data.tx_byte  = crc_reg[7:0];
            end
            S_TXHI:
            begin
                out_push          = !out_full;
                out_data.out_kind = KIND_TX;
                out_data.tx_byte  = crc_reg[15:8];
                out_data.last     = 1'b1;
                diag_tx_inc       = !out_full;
            end
            S_DONE:
                frame_done = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vld_reg   <= 1'b0;
            for (int i = 0; i < HOLDING_COUNT; i++) hold_reg[i] <= '0;
            for (int i = 0; i < INPUT_COUNT; i++) inr_reg[i] <= '0;
            for (int i = 0; i < DIAG_COUNT; i++) diag_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
            if (hold_we)
                hold_reg[hold_widx[HAW-1:0]] <= hold_wdata;
            if (inr_we)
                inr_reg[cmd_data.idx[IAW-1:0]] <= cmd_data.value;
            if (diag_rx_inc)
                diag_reg[DIAG_COUNT-2] <= diag_reg[DIAG_COUNT-2] + 1'b1;
            if (diag_tx_inc)
                diag_reg[DIAG_COUNT-1] <= diag_reg[DIAG_COUNT-1] + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg  <= len_next;
        rd_reg   <= rd_next;
        pidx_reg <= pidx_next;
        crc_reg  <= crc_next;
        hdr_reg  <= hdr_next;
        clo_reg  <= clo_next;
        chi_reg  <= chi_next;
        code_reg <= code_next;
        whi_reg  <= whi_next;
        mode_reg <= mode_next;
        src_reg  <= src_next;
        j_reg    <= j_next;
        wi_reg   <= wi_next;
    end

endmodule

`default_nettype wire

>>> rtl/modbus_rtu_slave_register_server_core.sv
// Top level of the Modbus RTU slave register server: config registers,
// receive RAM, front, back and queues. Uses mrs_pkg, mrs_ram, mrs_fifo, mrs_front, mrs_back.
//
//   channel   handshake          payload
//   input     push / full        func, data_byte, reg_index, reg_value
//   result    pop / empty        out_kind, tx_byte, last, written_index, written_value
//   config    psel/penable/...   paddr, pwdata, prdata (slave_address, gap_timeout_ticks)
//
// A byte, tick or input register transaction is taken whenever full is low.
// A completed frame holds full while the back end serves it: the CRC pass
// through the receive RAM and the check, a single register write or a
// read and write of each register of a multiple write, then the response
// bytes and a release, plus the time the result queue is stalled.
// Reset is asynchronous; the register banks read zero after reset, no clearing
// pass; slave_address resets to 255 and gap_timeout_ticks to 4.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_slave_register_server_core
    import mrs_pkg::*;
#(
    parameter int RX_BUF_BYTES  = RX_BUF_BYTES_DEF,
    parameter int HOLDING_COUNT = HOLDING_COUNT_DEF,
    parameter int INPUT_COUNT   = INPUT_COUNT_DEF,
    parameter int DIAG_COUNT    = DIAG_COUNT_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output      logic [PDATA_W-1:0] prdata,
    output      logic               pready,
    input  wire logic               push,
    output      logic               full,
    input  wire logic [1:0]         func,
    input  wire logic [7:0]         data_byte,
    input  wire logic [3:0]         reg_index,
    input  wire logic [15:0]        reg_value,
    output      logic               empty,
    input  wire logic               pop,
    output      logic               out_kind,
    output      logic [7:0]         tx_byte,
    output      logic               last,
    output      logic [3:0]         written_index,
    output      logic [15:0]        written_value
);

    localparam int AW = $clog2(RX_BUF_BYTES);

    logic [7:0]  sa_reg;
    logic [15:0] gto_reg;
    logic        cfg_wr;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_rdata;
    logic          cmd_push, cmd_full, cmd_pop, cmd_empty, frame_done;
    cmd_t          cmd_wdata, cmd_rdata;
    logic          res_push, res_full;
    res_t          res_wdata, res_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_GAP_TICKS) ? PDATA_W'(gto_reg) : PDATA_W'(sa_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_reg  <= SA_RESET;
            gto_reg <= GTO_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_SLAVE_ADDR)
                sa_reg <= pwdata[7:0];
            else
                gto_reg <= pwdata[15:0];
        end
    end

    mrs_ram #(
        .WIDTH (8),
        .DEPTH (RX_BUF_BYTES)
    ) u_rx_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (data_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mrs_front #(
        .RX_BUF_BYTES (RX_BUF_BYTES)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .func              (func),
        .data_byte         (data_byte),
        .reg_index         (reg_index),
        .reg_value         (reg_value),
        .slave_address     (sa_reg),
        .gap_timeout_ticks (gto_reg),
        .ram_we            (ram_we),
        .ram_waddr         (ram_waddr),
        .cmd_push          (cmd_push),
        .cmd_data          (cmd_wdata),
        .cmd_full          (cmd_full),
        .frame_done        (frame_done)
    );

    mrs_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_wdata),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_rdata),
        .empty   (cmd_empty)
    );

    mrs_back #(
        .RX_BUF_BYTES  (RX_BUF_BYTES),
        .HOLDING_COUNT (HOLDING_COUNT),
        .INPUT_COUNT   (INPUT_COUNT),
        .DIAG_COUNT    (DIAG_COUNT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .slave_address (sa_reg),
        .cmd_pop       (cmd_pop),
        .cmd_data      (cmd_rdata),
        .cmd_empty     (cmd_empty),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .out_push      (res_push),
        .out_data      (res_wdata),
        .out_full      (res_full),
        .frame_done    (frame_done)
    );

    mrs_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_FIFO_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_wdata),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rdata),
        .empty   (empty)
    );

    assign out_kind      = res_rdata.out_kind;
    assign tx_byte       = res_rdata.tx_byte;
    assign last          = res_rdata.last;
    assign written_index = res_rdata.written_index;
    assign written_value = res_rdata.written_value;

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the Modbus RTU slave register server core.
// Depends on rtl/mrs_pkg.sv and the core; predicts every transmit byte and
// holding register notice from its own model of the slave.
`timescale 1ns / 1ps

module tb;
    import mrs_pkg::*;

    localparam int LIMIT_CYC = 1000000;
    localparam int DRAIN_CYC = 300;
    localparam int HOLD_CYC  = 400;
    localparam int NREG_HOLD = 16;
    localparam int NREG_IN   = 16;
    localparam int NREG_DIAG = 8;
    localparam int RXB_BYTES = 64;

    typedef enum int { ROW_FRAME, ROW_TICK, ROW_INREG, ROW_NONE } row_kind_t;

    typedef struct {
        row_kind_t  rk;
        logic [7:0] addr;
        logic [7:0] fn;
        logic [15:0] a;
        logic [15:0] q;
        logic [7:0] bc;
        logic [7:0] fill;
        bit         bad;
        logic [7:0] exc;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;
    logic push = 1'b0;
    logic full;
    logic [1:0] func = FUNC_NONE;
    logic [7:0] data_byte = '0;
    logic [3:0] reg_index = '0;
    logic [15:0] reg_value = '0;
    logic empty;
    logic pop = 1'b0;
    logic out_kind;
    logic [7:0] tx_byte;
    logic last;
    logic [3:0] written_index;
    logic [15:0] written_value;

    res_t resp_q[$];
    int   errors = 0;
    int   cyc = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   hold_start = -1;
    int   hold_cnt = 0;
    int   sent = 0;

    logic [7:0]  m_sa;
    logic [15:0] m_gto;
    logic [7:0]  m_rx[RXB_BYTES];
    int          m_rxn;
    logic [15:0] m_gtmr;
    logic [15:0] m_hold[NREG_HOLD];
    logic [15:0] m_in[NREG_IN];
    logic [15:0] m_diag[NREG_DIAG];
    int          step_n;

    row_t rows[$];

    modbus_rtu_slave_register_server_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full), .func(func), .data_byte(data_byte),
        .reg_index(reg_index), .reg_value(reg_value),
        .empty(empty), .pop(pop), .out_kind(out_kind), .tx_byte(tx_byte),
        .last(last), .written_index(written_index), .written_value(written_value)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > LIMIT_CYC)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [15:0] crc16_upd(logic [15:0] c, logic [7:0] d);
        logic [15:0] r;
        r = c ^ {8'h00, d};
        for (int k = 0; k < 8; k++)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic void add_resp(logic k, logic [7:0] b, logic [3:0] i, logic [15:0] v);
        res_t r;
        if (step_n >= 64)
            return;
        r.out_kind = k;
        r.tx_byte = b;
        r.last = 1'b0;
        r.written_index = i;
        r.written_value = v;
        resp_q.push_back(r);
        step_n++;
    endfunction

    function automatic void send_reply(logic [7:0] bq[$]);
        logic [15:0] c;
        c = CRC_SEED;
        foreach (bq[i])
        begin
            c = crc16_upd(c, bq[i]);
            add_resp(KIND_TX, bq[i], 4'd0, 16'd0);
        end
        add_resp(KIND_TX, c[7:0], 4'd0, 16'd0);
        add_resp(KIND_TX, c[15:8], 4'd0, 16'd0);
        m_diag[NREG_DIAG-1] = m_diag[NREG_DIAG-1] + 16'd1;
    endfunction

    function automatic void send_exc(bit bcast, logic [7:0] fn, logic [7:0] code);
        logic [7:0] bq[$];
        if (bcast)
            return;
        bq = '{m_sa, fn | EXC_FLAG, code};
        send_reply(bq);
    endfunction

    function automatic logic [15:0] reg_read(logic [7:0] fn, int i);
        if (fn == FN_READ_HOLDING)
            return m_hold[i];
        else if (fn == FN_READ_INPUT)
            return m_in[i];
        return m_diag[i];
    endfunction

    function automatic void serve_read(bit bcast, logic [7:0] fn, int cnt);
        int st;
        int qty;
        logic [7:0] bq[$];
        logic [15:0] v;
        st = {m_rx[2], m_rx[3]};
        qty = {m_rx[4], m_rx[5]};
        if (bcast)
            return;
        if (st + qty > cnt)
        begin
            send_exc(1'b0, fn, EXC_ILLEGAL_ADDR);
            return;
        end
        bq = '{m_sa, fn, 8'(2 * qty)};
        for (int i = 0; i < qty; i++)
        begin
            v = reg_read(fn, st + i);
            bq.push_back(v[15:8]);
            bq.push_back(v[7:0]);
        end
        send_reply(bq);
    endfunction

    function automatic void write_hold(int idx, logic [15:0] v);
        if (idx < NREG_HOLD)
        begin
            m_hold[idx] = v;
            add_resp(KIND_NOTICE, 8'd0, 4'(idx), v);
        end
    endfunction

    function automatic void serve_frame(int n);
        logic [15:0] c;
        logic [7:0] fn;
        bit bcast;
        int st;
        int qty;
        int bcnt;
        logic [7:0] bq[$];
        c = CRC_SEED;
        fn = m_rx[1];
        bcast = (m_rx[0] == 8'd0);
        for (int i = 0; i + 2 < n; i++)
            c = crc16_upd(c, m_rx[i]);
        if ({m_rx[n-1], m_rx[n-2]} != c)
            return;
        m_diag[NREG_DIAG-2] = m_diag[NREG_DIAG-2] + 16'd1;
        st = {m_rx[2], m_rx[3]};
        qty = {m_rx[4], m_rx[5]};
        bcnt = m_rx[6];
        bq = '{m_sa, fn, m_rx[2], m_rx[3], m_rx[4], m_rx[5]};
        if (fn == FN_READ_HOLDING)
            serve_read(bcast, fn, NREG_HOLD);
        else if (fn == FN_READ_INPUT)
            serve_read(bcast, fn, NREG_IN);
        else if (fn == FN_DIAG)
            serve_read(bcast, fn, NREG_DIAG);
        else if (fn == FN_WRITE_SINGLE)
        begin
            if (st >= NREG_HOLD)
            begin
                send_exc(bcast, fn, EXC_ILLEGAL_VALUE);
                return;
            end
            write_hold(st, {m_rx[4], m_rx[5]});
            if (!bcast)
                send_reply(bq);
        end
        else if (fn == FN_WRITE_MULTI)
        begin
            if (bcnt != 2 * qty || st + qty > NREG_HOLD)
            begin
                send_exc(bcast, fn, EXC_ILLEGAL_VALUE);
                return;
            end
            for (int i = 0; i < qty; i++)
                write_hold(st + i, {m_rx[7+2*i], m_rx[8+2*i]});
            if (!bcast)
                send_reply(bq);
        end
        else
            send_exc(bcast, fn, EXC_ILLEGAL_FUNC);
    endfunction

    function automatic void take_rx(logic [7:0] d);
        int need;
        logic [7:0] fn;
        m_gtmr = 16'd0;
        if (m_rxn >= RXB_BYTES)
            return;
        m_rx[m_rxn] = d;
        m_rxn++;
        if (m_rxn <= 4)
            return;
        if (m_rx[0] != m_sa && m_rx[0] != 8'd0)
        begin
            m_rxn = 0;
            return;
        end
        fn = m_rx[1];
        if ((fn >= FN_READ_COILS && fn <= FN_WRITE_SINGLE) || fn == FN_DIAG)
            need = 8;
        else if (fn == FN_WRITE_COILS || fn == FN_WRITE_MULTI)
        begin
            if (m_rxn < 7)
                return;
            need = m_rx[6] + 9;
        end
        else
        begin
            m_rxn = 0;
            return;
        end
        if (m_rxn == need)
        begin
            m_rxn = 0;
            serve_frame(need);
        end
    endfunction

    function automatic void slave_step(logic [1:0] f, logic [7:0] b, logic [3:0] i,
                                       logic [15:0] v);
        int n0;
        res_t r;
        n0 = resp_q.size();
        step_n = 0;
        if (f == FUNC_BYTE)
            take_rx(b);
        else if (f == FUNC_TICK)
        begin
            if (m_gtmr != 16'hFFFF)
                m_gtmr = m_gtmr + 16'd1;
            if (m_gtmr >= m_gto)
            begin
                m_gtmr = 16'd0;
                m_rxn = 0;
            end
        end
        else if (f == FUNC_INREG)
            m_in[i] = v;
        if (resp_q.size() > n0)
        begin
            r = resp_q[$];
            r.last = 1'b1;
            resp_q[$] = r;
        end
    endfunction

    // receiver: pop at random, check every transaction
    always @(posedge clk)
    begin
        res_t e;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (resp_q.size() == 0)
                begin
                    $error("unexpected result kind=%0d byte=%02h", out_kind, tx_byte);
                    errors++;
                end
                else
                begin
                    e = resp_q.pop_front();
                    if (out_kind !== e.out_kind)
                    begin
                        $error("out_kind exp %0d got %0d", e.out_kind, out_kind);
                        errors++;
                    end
                    if (tx_byte !== e.tx_byte)
                    begin
                        $error("tx_byte exp %02h got %02h", e.tx_byte, tx_byte);
                        errors++;
                    end
                    if (last !== e.last)
                    begin
                        $error("last exp %0d got %0d", e.last, last);
                        errors++;
                    end
                    if (written_index !== e.written_index)
                    begin
                        $error("written_index exp %0d got %0d", e.written_index,
                               written_index);
                        errors++;
                    end
                    if (written_value !== e.written_value)
                    begin
                        $error("written_value exp %04h got %04h", e.written_value,
                               written_value);
                        errors++;
                    end
                end
            end
            if (cyc == hold_start)
                hold_cnt = HOLD_CYC;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic put(input logic [1:0] f, input logic [7:0] b, input logic [3:0] i,
                       input logic [15:0] v);
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        func <= f;
        data_byte <= b;
        reg_index <= i;
        reg_value <= v;
        do @(posedge clk); while (full);
        slave_step(f, b, i, v);
        sent++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        put(FUNC_BYTE, b, 4'($urandom), 16'($urandom));
    endtask

    task automatic put_ticks(input int n);
        for (int k = 0; k < n; k++)
            put(FUNC_TICK, 8'($urandom), 4'($urandom), 16'($urandom));
    endtask

    // send a request; keep only the first nkeep bytes when truncating
    task automatic put_frame(input row_t r, input int nkeep);
        logic [7:0] bq[$];
        logic [15:0] c;
        bq = '{r.addr, r.fn, r.a[15:8], r.a[7:0], r.q[15:8], r.q[7:0]};
        if (r.fn == FN_WRITE_COILS || r.fn == FN_WRITE_MULTI)
        begin
            bq.push_back(r.bc);
            for (int k = 0; k < r.bc; k++)
                bq.push_back(r.fill + 8'(k));
        end
        c = CRC_SEED;
        foreach (bq[k])
            c = crc16_upd(c, bq[k]);
        if (r.bad)
            c = c ^ 16'h0100;
        bq.push_back(c[7:0]);
        bq.push_back(c[15:8]);
        foreach (bq[k])
            if (nkeep < 0 || k < nkeep)
                put_byte(bq[k]);
    endtask

    task automatic cfg_write(input logic idx, input logic [PDATA_W-1:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_SLAVE_ADDR)
            m_sa = val[7:0];
        else
            m_gto = val[15:0];
    endtask

    task automatic wait_drain();
        push <= 1'b0;
        while (resp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    function automatic row_t mk(row_kind_t rk, logic [7:0] addr, logic [7:0] fn,
                                logic [15:0] a, logic [15:0] q, logic [7:0] bc,
                                logic [7:0] fill, bit bad, logic [7:0] exc);
        row_t r;
        r.rk = rk; r.addr = addr; r.fn = fn; r.a = a; r.q = q;
        r.bc = bc; r.fill = fill; r.bad = bad; r.exc = exc;
        return r;
    endfunction

    task automatic rand_request();
        row_t r;
        int pick;
        int nkeep;
        logic [7:0] fns[12];
        fns = '{FN_READ_HOLDING, FN_READ_INPUT, FN_DIAG, FN_WRITE_SINGLE, FN_WRITE_MULTI,
                FN_WRITE_MULTI, FN_READ_HOLDING, FN_READ_COILS, FN_READ_DISCRETE,
                FN_WRITE_COIL, FN_WRITE_COILS, 8'h00};
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            put(FUNC_INREG, 8'($urandom), 4'($urandom), 16'($urandom));
            return;
        end
        if (pick < 11)
        begin
            put(FUNC_NONE, 8'($urandom), 4'($urandom), 16'($urandom));
            return;
        end
        pick = $urandom_range(99);
        r.rk = ROW_FRAME;
        r.addr = (pick < 70) ? m_sa : (pick < 85) ? 8'd0 : 8'($urandom);
        r.fn = fns[$urandom_range(11)];
        if (r.fn == 8'h00)
            r.fn = 8'($urandom);
        r.a = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(17));
        r.q = ($urandom_range(9) == 0) ? 16'($urandom_range(17)) : 16'($urandom_range(4));
        if (r.fn == FN_WRITE_SINGLE)
            r.q = 16'($urandom);
        else if ($urandom_range(19) == 0)
            r.q = 16'($urandom);
        r.bc = ($urandom_range(9) == 0) ? 8'($urandom_range(9)) : 8'(2 * r.q);
        if (r.bc > 40)
            r.bc = 8'($urandom_range(40));
        r.fill = 8'($urandom);
        r.bad = ($urandom_range(99) < 8);
        nkeep = -1;
        if (m_gto <= 8 && $urandom_range(99) < 8)
            nkeep = $urandom_range(1, 6);
        put_frame(r, nkeep);
        if (nkeep >= 0)
            put_ticks(m_gto);
        else
            put_ticks($urandom_range(2));
    endtask

    initial
    begin
        int pstart;
        bit paused;
        logic [7:0] sa_set[4];
        logic [15:0] gto_set[4];
        int idle_set[4];
        int stall_set[4];

        m_sa = SA_RESET;
        m_gto = GTO_RESET;
        m_rxn = 0;
        m_gtmr = 16'd0;
        paused = 1'b0;
        foreach (m_rx[i]) m_rx[i] = 8'd0;
        foreach (m_hold[i]) m_hold[i] = 16'd0;
        foreach (m_in[i]) m_in[i] = 16'd0;
        foreach (m_diag[i]) m_diag[i] = 16'd0;

        rows.push_back(mk(ROW_FRAME, 8'hFF, FN_READ_HOLDING, 0, 2, 0, 0, 0, 0));
        rows.push_back(mk(ROW_FRAME, 8'hFF, FN_READ_HOLDING, 0, 17, 0, 0, 0, EXC_ILLEGAL_ADDR));
        rows.push_back(mk(ROW_FRAME, 8'hFF, FN_WRITE_SINGLE, 15, 16'hFFFF, 0, 0, 0, 0));
        rows.push_back(mk(ROW_FRAME, 8'hFF, FN_WRITE_SINGLE, 16, 0, 0, 0, 0, EXC_ILLEGAL_VALUE));
        rows.push_back(mk(ROW_FRAME, 8'hFF, FN_WRITE_MULTI, 0, 2, 4, 8'hFE, 0, 0));
        rows.push_back(mk(ROW_FRAME, 8'hFF, FN_WRITE_MULTI, 0, 2, 3, 8'h10, 0,
                          EXC_ILLEGAL_VALUE));
        rows.push_back(mk(ROW_FRAME, 8'hFF, FN_WRITE_MULTI, 15, 2, 4, 8'h20, 0,
                          EXC_ILLEGAL_VALUE));
        rows.push_back(mk(ROW_FRAME, 8'hFF, FN_READ_COILS, 0, 1, 0, 0, 0, EXC_ILLEGAL_FUNC));
        rows.push_back(mk(ROW_FRAME, 8'hFF, FN_WRITE_COILS, 0, 1, 2, 8'h55, 0,
                          EXC_ILLEGAL_FUNC));
        rows.push_back(mk(ROW_INREG, 0, 0, 15, 16'hFFFF, 0, 0, 0, 0));
        rows.push_back(mk(ROW_INREG, 0, 0, 0, 16'h0000, 0, 0, 0, 0));
        rows.push_back(mk(ROW_INREG, 0, 0, 7, 16'h1234, 0, 0, 0, 0));
        rows.push_back(mk(ROW_FRAME, 8'hFF, FN_READ_INPUT, 0, 16, 0, 0, 0, 0));
        rows.push_back(mk(ROW_FRAME, 8'hFF, FN_DIAG, 0, 8, 0, 0, 0, 0));
        rows.push_back(mk(ROW_FRAME, 8'hFF, FN_READ_HOLDING, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(ROW_FRAME, 8'hFF, FN_READ_HOLDING, 0, 1, 0, 0, 1, 0));
        rows.push_back(mk(ROW_FRAME, 8'h00, FN_WRITE_SINGLE, 3, 16'hABCD, 0, 0, 0, 0));
        rows.push_back(mk(ROW_FRAME, 8'h00, FN_WRITE_MULTI, 14, 4, 8, 8'h01, 0, 0));
        rows.push_back(mk(ROW_FRAME, 8'h00, FN_READ_HOLDING, 0, 1, 0, 0, 0, 0));
        rows.push_back(mk(ROW_FRAME, 8'h12, FN_READ_HOLDING, 0, 1, 0, 0, 0, 0));
        rows.push_back(mk(ROW_TICK, 0, 0, 0, 4, 0, 0, 0, 0));
        rows.push_back(mk(ROW_FRAME, 8'hFF, 8'h07, 0, 1, 0, 0, 0, 0));
        rows.push_back(mk(ROW_TICK, 0, 0, 0, 4, 0, 0, 0, 0));
        rows.push_back(mk(ROW_FRAME, 8'hFF, FN_WRITE_MULTI, 0, 2, 56, 8'h80, 0, 0));
        rows.push_back(mk(ROW_TICK, 0, 0, 0, 4, 0, 0, 0, 0));
        rows.push_back(mk(ROW_NONE, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(ROW_FRAME, 8'hFF, FN_READ_HOLDING, 0, 16, 0, 0, 0, 0));

        sa_set = '{8'd1, 8'd255, 8'($urandom_range(2, 254)), 8'($urandom_range(1, 254))};
        gto_set = '{16'd1, 16'hFFFF, 16'($urandom_range(2, 20)), 16'd4};
        idle_set = '{0, 47, 0, 20};
        stall_set = '{0, 0, 47, 20};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[n])
        begin
            case (rows[n].rk)
                ROW_FRAME: put_frame(rows[n], -1);
                ROW_TICK:  put_ticks(rows[n].q);
                ROW_INREG: put(FUNC_INREG, 8'($urandom), rows[n].a[3:0], rows[n].q);
                default:   put(FUNC_NONE, 8'hFF, 4'hF, 16'hFFFF);
            endcase
            if (rows[n].exc != 8'd0 && rows[n].addr != 8'd0)
                if (resp_q.size() < 5 || resp_q[$-2].tx_byte != rows[n].exc)
                begin
                    $error("exception code exp %02h not predicted", rows[n].exc);
                    errors++;
                end
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            wait_drain();
            cfg_write(REG_SLAVE_ADDR, PDATA_W'(sa_set[ph]));
            cfg_write(REG_GAP_TICKS, PDATA_W'(gto_set[ph]));
            idle_pct = idle_set[ph];
            stall_pct = stall_set[ph];
            @(posedge clk);
            if (ph == 2)
            begin
                hold_start = cyc + 5;
                put_frame(mk(ROW_FRAME, m_sa, FN_READ_HOLDING, 16'd0, 16'd16, 8'd0,
                             8'd0, 1'b0, 8'd0), -1);
            end
            pstart = sent;
            while (sent - pstart < 8)
            begin
                rand_request();
                if (ph == 3 && !paused)
                begin
                    push <= 1'b0;
                    while (resp_q.size() != 0)
                        @(posedge clk);
                    paused = 1'b1;
                end
            end
        end

        push <= 1'b0;
        while (resp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/mrs_pkg.sv
rtl/mrs_ram.sv
rtl/mrs_fifo.sv
rtl/mrs_front.sv
rtl/mrs_back.sv
rtl/modbus_rtu_slave_register_server_core.sv
tb/tb.sv
